// ===== hw/rtl/uvs_pkg.sv =====
// Shared types, constants and the sine table builder for the UV sphere vertex generator.
// No dependencies; every other file of the block but uvs_divider uses this package.
package uvs_pkg;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_SECTOR_COUNT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STACK_COUNT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPHERE_RADIUS = 2'd2;

  // Register widths and reset values.
  localparam int CountW  = 10;
  localparam int RadiusW = 16;
  localparam logic [CountW-1:0]  SectorReset = 10'd10;
  localparam logic [CountW-1:0]  StackReset  = 10'd10;
  localparam logic [RadiusW-1:0] RadiusReset = 16'd128;
  localparam int MinSectors = 4;
  localparam int MinStacks  = 3;

  // Result field widths.
  localparam int PosW  = 17;
  localparam int NormW = 16;
  localparam int TexW  = 17;
  localparam int VtxW  = 21;

  // Datapath operation codes.
  typedef enum logic [2:0] {
    MUL_NONE, MUL_RS, MUL_PZ, MUL_NX, MUL_NY, MUL_PX, MUL_PY
  } mul_op_e;

  typedef enum logic [1:0] {DIV_TI, DIV_PI, DIV_U, DIV_V} div_sel_e;

  typedef enum logic [1:0] {TRIG_ST, TRIG_CT, TRIG_SP, TRIG_CP} trig_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      div_start;
    div_sel_e  div_sel;
    logic      div_store;
    logic      trig_en;
    trig_sel_e trig_sel;
    mul_op_e   mul_op;
    logic      out_load;
  } uvs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } uvs_stat_t;

  // Quotient of two constants by shift and subtract; only evaluated at elaboration.
  function automatic longint unsigned const_quo(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter wave sine entry k in Q1.14, from a Taylor series in Q2.30.
  // Only evaluated at elaboration with constant arguments.
  function automatic logic [15:0] qsin(input int unsigned k, input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (longint'(k) * 64'd6746518852) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned n = 1; n <= 12; n++) begin
      term = (term * x2) >> 30;
      term = const_quo(term, 64'((2 * n) * (2 * n + 1)));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (longint'(sum) + 64'd32768) >> 16;
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    return q[15:0];
  endfunction

endpackage

// ===== hw/rtl/uvs_if.sv =====
// Valid/ready channel interfaces for vertex requests and generated vertices.
// Depends on uvs_pkg for the field widths.
interface uvs_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface uvs_vtx_if;
  logic                               valid;
  logic                               ready;
  logic signed [uvs_pkg::PosW-1:0]    pos_x;
  logic signed [uvs_pkg::PosW-1:0]    pos_y;
  logic signed [uvs_pkg::PosW-1:0]    pos_z;
  logic signed [uvs_pkg::NormW-1:0]   norm_x;
  logic signed [uvs_pkg::NormW-1:0]   norm_y;
  logic signed [uvs_pkg::NormW-1:0]   norm_z;
  logic [uvs_pkg::TexW-1:0]           tex_u;
  logic [uvs_pkg::TexW-1:0]           tex_v;
  logic [uvs_pkg::VtxW-1:0]           vertex_number;
  logic                               last_vertex;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output norm_x,
                  output norm_y, output norm_z, output tex_u, output tex_v,
                  output vertex_number, output last_vertex, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input norm_x,
                input norm_y, input norm_z, input tex_u, input tex_v,
                input vertex_number, input last_vertex, output ready);
endinterface

// ===== hw/rtl/uvs_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used by uvs_datapath for angle indices and texture coordinates.
module uvs_divider #(
  parameter int DW   = 28,
  parameter int DENW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DW-1:0]   dividend_i,
  input  logic [DENW-1:0] divisor_i,
  output logic [DW-1:0]   quotient_o,
  output logic            done_o
);

  localparam int RW = DENW + 1;
  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q;
  logic [RW-1:0]   rem_q;
  logic [DENW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [RW-1:0]   rem_shift;
  logic            fits;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_shift = {rem_q[RW-2:0], quo_q[DW-1]};
  assign fits      = rem_shift >= {1'b0, den_q};

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_shift - {1'b0, den_q}) : rem_shift;
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== hw/rtl/uvs_datapath.sv =====
// Datapath: configuration, vertex position state, divider, sine table and shared multiplier.
// Depends on uvs_pkg and uvs_divider; driven by commands from uvs_ctrl.
module uvs_datapath #(
  parameter int MAX_DIVISIONS   = 1023,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [uvs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [uvs_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             restart_i,
  input  uvs_pkg::uvs_cmd_t                cmd_i,
  output uvs_pkg::uvs_stat_t               stat_o,
  output logic signed [uvs_pkg::PosW-1:0]  pos_x_o,
  output logic signed [uvs_pkg::PosW-1:0]  pos_y_o,
  output logic signed [uvs_pkg::PosW-1:0]  pos_z_o,
  output logic signed [uvs_pkg::NormW-1:0] norm_x_o,
  output logic signed [uvs_pkg::NormW-1:0] norm_y_o,
  output logic signed [uvs_pkg::NormW-1:0] norm_z_o,
  output logic [uvs_pkg::TexW-1:0]         tex_u_o,
  output logic [uvs_pkg::TexW-1:0]         tex_v_o,
  output logic [uvs_pkg::VtxW-1:0]         vertex_number_o,
  output logic                             last_vertex_o
);

  import uvs_pkg::*;

  localparam int CW    = $clog2(MAX_DIVISIONS + 1);
  localparam int DW    = CW + 18;
  localparam int DENW  = CW + 1;
  localparam int ExtW  = 13;
  localparam int AngW  = TRIG_TABLE_BITS;
  localparam int IdxW  = TRIG_TABLE_BITS - 1;
  localparam int QDepth = (1 << (TRIG_TABLE_BITS - 2)) + 1;
  localparam int RadW  = RadiusW + 15;
  localparam int ProdW = RadW + 15;

  // Configuration registers.
  logic [CountW-1:0]  sector_cfg_q, stack_cfg_q;
  logic [RadiusW-1:0] radius_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_cfg_q <= SectorReset;
      stack_cfg_q  <= StackReset;
      radius_cfg_q <= RadiusReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECTOR_COUNT:  sector_cfg_q <= cfg_data_i[CountW-1:0];
        CFG_STACK_COUNT:   stack_cfg_q  <= cfg_data_i[CountW-1:0];
        CFG_SPHERE_RADIUS: radius_cfg_q <= cfg_data_i[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts, clamped to the supported range.
  logic [ExtW-1:0] sc_ext, tc_ext, s_clamp, t_clamp;

  always_comb begin
    sc_ext = ExtW'(sector_cfg_q);
    tc_ext = ExtW'(stack_cfg_q);
    if (sc_ext < ExtW'(MinSectors)) begin
      s_clamp = ExtW'(MinSectors);
    end else if (sc_ext > ExtW'(MAX_DIVISIONS)) begin
      s_clamp = ExtW'(MAX_DIVISIONS);
    end else begin
      s_clamp = sc_ext;
    end
    if (tc_ext < ExtW'(MinStacks)) begin
      t_clamp = ExtW'(MinStacks);
    end else if (tc_ext > ExtW'(MAX_DIVISIONS)) begin
      t_clamp = ExtW'(MAX_DIVISIONS);
    end else begin
      t_clamp = tc_ext;
    end
  end

  // Position state and the counts and radius of the current request.
  logic [CW-1:0]      stack_pos_q, sector_pos_q, s_q, t_q;
  logic [VtxW-1:0]    vcnt_q;
  logic [RadiusW-1:0] r_q;
  logic               last;

  assign last = (stack_pos_q == t_q) && (sector_pos_q == s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_pos_q  <= '0;
      sector_pos_q <= '0;
      vcnt_q       <= '0;
    end else if (cmd_i.capture) begin
      if (restart_i || (stack_pos_q > t_clamp[CW-1:0])
          || (sector_pos_q > s_clamp[CW-1:0])) begin
        stack_pos_q  <= '0;
        sector_pos_q <= '0;
        vcnt_q       <= '0;
      end
    end else if (cmd_i.out_load) begin
      if (last) begin
        stack_pos_q  <= '0;
        sector_pos_q <= '0;
        vcnt_q       <= '0;
      end else begin
        vcnt_q <= vcnt_q + VtxW'(1);
        if (sector_pos_q == s_q) begin
          sector_pos_q <= '0;
          stack_pos_q  <= stack_pos_q + CW'(1);
        end else begin
          sector_pos_q <= sector_pos_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q <= s_clamp[CW-1:0];
      t_q <= t_clamp[CW-1:0];
      r_q <= radius_cfg_q;
    end
  end

  // Divider operands: rounded angle indices and texture coordinates.
  logic [DW-1:0]   div_num, quotient;
  logic [DENW-1:0] div_den;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_TI: begin
        div_num = (DW'(stack_pos_q) << AngW) + DW'(t_q);
        div_den = {t_q, 1'b0};
      end
      DIV_PI: begin
        div_num = (DW'(sector_pos_q) << (AngW + 1)) + DW'(s_q);
        div_den = {s_q, 1'b0};
      end
      DIV_U: begin
        div_num = (DW'(sector_pos_q) << 17) + DW'(s_q);
        div_den = {s_q, 1'b0};
      end
      default: begin
        div_num = (DW'(stack_pos_q) << 17) + DW'(t_q);
        div_den = {t_q, 1'b0};
      end
    endcase
  end

  uvs_divider #(
    .DW   (DW),
    .DENW (DENW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (quotient),
    .done_o     (stat_o.div_done)
  );

  // Division results.
  logic [AngW-1:0] ti_q, pi_q;
  logic [TexW-1:0] u_q, v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DIV_TI:  ti_q <= quotient[AngW-1:0];
        DIV_PI:  pi_q <= quotient[AngW-1:0];
        DIV_U:   u_q  <= quotient[TexW-1:0];
        default: v_q  <= quotient[TexW-1:0];
      endcase
    end
  end

  // Quarter wave sine table, built at elaboration.
  logic [15:0] qtab [QDepth];

  for (genvar k = 0; k < QDepth; k++) begin : g_qtab
    localparam logic [15:0] Entry = qsin(k, TRIG_TABLE_BITS);
    assign qtab[k] = Entry;
  end

  // One table lookup per cycle; cosine is the sine a quarter turn ahead.
  logic [AngW-1:0]   ang;
  logic [1:0]        quad;
  logic [IdxW-1:0]   rem_idx, tab_idx;
  logic [15:0]       tab_val;
  logic signed [15:0] trig_val;

  always_comb begin
    case (cmd_i.trig_sel)
      TRIG_ST: ang = ti_q;
      TRIG_CT: ang = ti_q + AngW'(1 << (AngW - 2));
      TRIG_SP: ang = pi_q;
      default: ang = pi_q + AngW'(1 << (AngW - 2));
    endcase
    quad     = ang[AngW-1:AngW-2];
    rem_idx  = IdxW'(ang[AngW-3:0]);
    tab_idx  = quad[0] ? (IdxW'(1 << (AngW - 2)) - rem_idx) : rem_idx;
    tab_val  = qtab[tab_idx];
    trig_val = quad[1] ? -$signed(tab_val) : $signed(tab_val);
  end

  logic signed [15:0] st_q, ct_q, sp_q, cp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.trig_en) begin
      case (cmd_i.trig_sel)
        TRIG_ST: st_q <= trig_val;
        TRIG_CT: ct_q <= trig_val;
        TRIG_SP: sp_q <= trig_val;
        default: cp_q <= trig_val;
      endcase
    end
  end

  // Magnitudes of the trig values.
  logic [14:0] st_m, ct_m, sp_m, cp_m;

  assign st_m = st_q[15] ? 15'(-st_q) : st_q[14:0];
  assign ct_m = ct_q[15] ? 15'(-ct_q) : ct_q[14:0];
  assign sp_m = sp_q[15] ? 15'(-sp_q) : sp_q[14:0];
  assign cp_m = cp_q[15] ? 15'(-cp_q) : cp_q[14:0];

  // Shared multiplier with a product register.
  logic [RadW-1:0]  op_a, a_q;
  logic [14:0]      op_b;
  logic [ProdW-1:0] prod_q;
  mul_op_e          mtag_q;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_RS:  begin op_a = RadW'(r_q);  op_b = st_m; end
      MUL_PZ:  begin op_a = RadW'(r_q);  op_b = ct_m; end
      MUL_NX:  begin op_a = RadW'(st_m); op_b = cp_m; end
      MUL_NY:  begin op_a = RadW'(st_m); op_b = sp_m; end
      MUL_PX:  begin op_a = a_q;         op_b = cp_m; end
      MUL_PY:  begin op_a = a_q;         op_b = sp_m; end
      default: begin op_a = '0;          op_b = '0;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtag_q <= MUL_NONE;
    end else begin
      mtag_q <= cmd_i.mul_op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(op_a) * ProdW'(op_b);
  end

  // Round half up on the magnitude, then apply the sign.
  logic [ProdW-1:0] rnd28, rnd14;
  logic [PosW-1:0]  mag28, mag14p;
  logic [NormW-1:0] mag14n;
  logic             neg_x, neg_y;

  assign rnd28  = prod_q + ProdW'(1 << 27);
  assign rnd14  = prod_q + ProdW'(1 << 13);
  assign mag28  = rnd28[28 +: PosW];
  assign mag14p = rnd14[14 +: PosW];
  assign mag14n = rnd14[14 +: NormW];
  assign neg_x  = st_q[15] ^ cp_q[15];
  assign neg_y  = st_q[15] ^ sp_q[15];

  logic signed [PosW-1:0]  px_q, py_q, pz_q;
  logic signed [NormW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    case (mtag_q)
      MUL_RS: a_q  <= prod_q[RadW-1:0];
      MUL_PZ: pz_q <= ct_q[15] ? -$signed(mag14p) : $signed(mag14p);
      MUL_NX: nx_q <= neg_x ? -$signed(mag14n) : $signed(mag14n);
      MUL_NY: ny_q <= neg_y ? -$signed(mag14n) : $signed(mag14n);
      MUL_PX: px_q <= neg_x ? -$signed(mag28) : $signed(mag28);
      MUL_PY: py_q <= neg_y ? -$signed(mag28) : $signed(mag28);
      default: ;
    endcase
  end

  // Output register, loaded when the previous vertex has been taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_x_o         <= px_q;
      pos_y_o         <= py_q;
      pos_z_o         <= pz_q;
      norm_x_o        <= nx_q;
      norm_y_o        <= ny_q;
      norm_z_o        <= ct_q;
      tex_u_o         <= u_q;
      tex_v_o         <= v_q;
      vertex_number_o <= vcnt_q;
      last_vertex_o   <= last;
    end
  end

endmodule

// ===== hw/rtl/uvs_ctrl.sv =====
// Controller state machine: sequences the divisions, table lookups and multiplies.
// Depends on uvs_pkg; commands uvs_datapath and owns the handshakes.
module uvs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               vtx_valid_o,
  input  logic               vtx_ready_i,
  input  uvs_pkg::uvs_stat_t stat_i,
  output uvs_pkg::uvs_cmd_t  cmd_o
);

  import uvs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIV_GO   = 7'b0000010,
    ST_DIV_WAIT = 7'b0000100,
    ST_TRIG     = 7'b0001000,
    ST_MUL      = 7'b0010000,
    ST_FLUSH    = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.mul_op = MUL_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_DIV_GO;
          step_d  = '0;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = div_sel_e'(step_q[1:0]);
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        cmd_o.div_sel = div_sel_e'(step_q[1:0]);
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (step_q == 3'd3) begin
            state_d = ST_TRIG;
            step_d  = '0;
          end else begin
            state_d = ST_DIV_GO;
            step_d  = step_q + 3'd1;
          end
        end
      end
      ST_TRIG: begin
        cmd_o.trig_en  = 1'b1;
        cmd_o.trig_sel = trig_sel_e'(step_q[1:0]);
        if (step_q == 3'd3) begin
          state_d = ST_MUL;
          step_d  = '0;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_MUL: begin
        case (step_q)
          3'd0:    cmd_o.mul_op = MUL_RS;
          3'd1:    cmd_o.mul_op = MUL_PZ;
          3'd2:    cmd_o.mul_op = MUL_NX;
          3'd3:    cmd_o.mul_op = MUL_NY;
          3'd4:    cmd_o.mul_op = MUL_PX;
          default: cmd_o.mul_op = MUL_PY;
        endcase
        if (step_q == 3'd5) begin
          state_d = ST_FLUSH;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_FLUSH: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || vtx_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (vtx_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign vtx_valid_o = out_valid_q;

  // An accepted request always starts the first division.
  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == ST_DIV_GO)
    else $error("accepted request did not start a division");

  // A waiting vertex is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || vtx_ready_i))
    else $error("output register overwritten while not taken");

  // The divider only finishes while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside of a wait");

  // The last multiply is followed by the flush cycle.
  a_mul_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL && step_q == 3'd5 |=> state_q == ST_FLUSH)
    else $error("multiply sequence did not end in flush");

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator_unit.sv =====
// UV sphere vertex generator top level. Per vertex, the serial divider performs four divisions
// of W+18 quotient bits, W = clog2(MAX_DIVISIONS+1), followed by the table lookups, the
// multiplies and a flush; the vertex is then loaded into the output register. One request is
// taken at a time, the next only once the previous vertex sits in the output register; a
// stalled receiver holds back that load. Reset is asynchronous and active low: the counts
// go to 10, the radius to 128 and generation restarts at vertex zero.
module uv_sphere_vertex_generator_unit #(
  parameter int MAX_DIVISIONS   = 1023,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [uvs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [uvs_pkg::CfgDataW-1:0] cfg_data_i,
  uvs_req_if.sink                      req_i,
  uvs_vtx_if.source                    vtx_o
);

  import uvs_pkg::*;

  uvs_cmd_t  cmd;
  uvs_stat_t stat;

  // Sequencer.
  uvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .vtx_valid_o (vtx_o.valid),
    .vtx_ready_i (vtx_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  uvs_datapath #(
    .MAX_DIVISIONS   (MAX_DIVISIONS),
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .restart_i       (req_i.restart),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pos_x_o         (vtx_o.pos_x),
    .pos_y_o         (vtx_o.pos_y),
    .pos_z_o         (vtx_o.pos_z),
    .norm_x_o        (vtx_o.norm_x),
    .norm_y_o        (vtx_o.norm_y),
    .norm_z_o        (vtx_o.norm_z),
    .tex_u_o         (vtx_o.tex_u),
    .tex_v_o         (vtx_o.tex_v),
    .vertex_number_o (vtx_o.vertex_number),
    .last_vertex_o   (vtx_o.last_vertex)
  );

endmodule
